@@ src/cmhf_pkg.sv @@
// Shared constants and types of the circular mean heading filter.
package cmhf_pkg;

   // Width of the CORDIC x, y and z registers (Q2.30 plus guard bits).
   localparam int CORDIC_W     = 34;
   localparam int CORDIC_ITERS = 16;
   localparam int ITER_W       = 4;

   // Control word from the sequencer to the shared CORDIC unit.
   typedef struct packed {
      logic              load;
      logic              step;
      logic              vec_mode;
      logic [ITER_W-1:0] iter;
   } cordic_ctrl_type;

endpackage

@@ src/cmhf_ring.sv @@
// Sample ring of the last WINDOW headings with per-entry valid bits.
module cmhf_ring #(
   parameter int WINDOW     = 10,
   parameter int ANGLE_BITS = 16,
   parameter int PTR_W      = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [ANGLE_BITS-1:0] wr_data,
   input  logic [PTR_W-1:0]      rd_addr,
   output logic [ANGLE_BITS-1:0] rd_data
);

   logic [ANGLE_BITS-1:0] ring_ff [WINDOW];
   logic [WINDOW-1:0]     valid_ff;
   logic [WINDOW-1:0]     valid_in;
   logic [PTR_W-1:0]      wr_pos_ff;
   logic [PTR_W-1:0]      wr_pos_in;
   logic [ANGLE_BITS-1:0] rd_word_ff;
   logic                  rd_valid_ff;

   always_comb begin
      valid_in  = valid_ff;
      wr_pos_in = wr_pos_ff;
      if (wr_en) begin
         valid_in[wr_pos_ff] = 1'b1;
         if (wr_pos_ff == PTR_W'(WINDOW - 1)) begin
            wr_pos_in = '0;
         end else begin
            wr_pos_in = wr_pos_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         wr_pos_ff   <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         wr_pos_ff   <= wr_pos_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_pos_ff] <= wr_data;
      end
      rd_word_ff <= ring_ff[rd_addr];
   end

   // Unwritten slots read as heading zero.
   assign rd_data = rd_valid_ff ? rd_word_ff : '0;

endmodule

@@ src/cmhf_cordic.sv @@
// Shared CORDIC unit: one rotation or vectoring iteration per cycle while ctrl.step is set.
module cmhf_cordic (
   input  logic                                  clock,
   input  cmhf_pkg::cordic_ctrl_type             ctrl,
   input  logic signed [cmhf_pkg::CORDIC_W-1:0]  load_x,
   input  logic signed [cmhf_pkg::CORDIC_W-1:0]  load_y,
   input  logic signed [cmhf_pkg::CORDIC_W-1:0]  load_z,
   output logic signed [cmhf_pkg::CORDIC_W-1:0]  x,
   output logic signed [cmhf_pkg::CORDIC_W-1:0]  y,
   output logic signed [cmhf_pkg::CORDIC_W-1:0]  z
);
   import cmhf_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff;
   logic signed [CORDIC_W-1:0] y_ff;
   logic signed [CORDIC_W-1:0] z_ff;
   logic signed [CORDIC_W-1:0] x_in;
   logic signed [CORDIC_W-1:0] y_in;
   logic signed [CORDIC_W-1:0] z_in;
   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] atan_step;
   logic                       y_pos;
   logic                       ccw;

   // Arctangent of 2^-i in 2^32-per-turn units.
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
      logic signed [CORDIC_W-1:0] v;
      unique case (idx)
         4'd0:    v = CORDIC_W'(536870912);
         4'd1:    v = CORDIC_W'(316933406);
         4'd2:    v = CORDIC_W'(167458907);
         4'd3:    v = CORDIC_W'(85004756);
         4'd4:    v = CORDIC_W'(42667331);
         4'd5:    v = CORDIC_W'(21354465);
         4'd6:    v = CORDIC_W'(10679838);
         4'd7:    v = CORDIC_W'(5340245);
         4'd8:    v = CORDIC_W'(2670163);
         4'd9:    v = CORDIC_W'(1335087);
         4'd10:   v = CORDIC_W'(667544);
         4'd11:   v = CORDIC_W'(333772);
         4'd12:   v = CORDIC_W'(166886);
         4'd13:   v = CORDIC_W'(83443);
         4'd14:   v = CORDIC_W'(41722);
         default: v = CORDIC_W'(20861);
      endcase
      return v;
   endfunction

   always_comb begin
      dx        = y_ff >>> ctrl.iter;
      dy        = x_ff >>> ctrl.iter;
      atan_step = atan_turn(ctrl.iter);
      y_pos     = !y_ff[CORDIC_W-1] && (y_ff != '0);
      // Rotation follows the sign of z, vectoring drives y toward zero.
      ccw       = ctrl.vec_mode ? !y_pos : !z_ff[CORDIC_W-1];
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      priority if (ctrl.load) begin
         x_in = load_x;
         y_in = load_y;
         z_in = load_z;
      end else if (ctrl.step) begin
         if (ccw) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_step;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;

endmodule

@@ src/circular_mean_heading_filter.sv @@
// Circular mean heading filter: usage
// One heading per req_ transaction (binary angle, only the low ANGLE_BITS
// bits count). The heading goes into a ring of the last WINDOW samples,
// cleared to zero by reset. The block then runs every ring entry through a
// shared CORDIC unit in rotation mode, sums the sines and cosines in Q1.15,
// and runs one vectoring pass on the sums to get the mean heading.
// One rsp_ transaction per request: rsp_mean_heading, and
// rsp_no_direction when both sums are zero (heading then reads 0).
// Each ring entry costs one read, one load, 16 rotation steps and one
// accumulate on the single CORDIC unit; the vectoring pass is skipped
// when both sums are zero.
// req_ready is high only while the sequencer is idle, so a new heading is
// accepted only after the previous result has left the sequencer.
// The result register frees req_ready while a result waits; if the receiver
// stalls with a result pending, the next result holds in the sequencer until
// rsp_ready takes the old one.
// Synchronous active high reset empties the ring and drops any pending result.
module circular_mean_heading_filter #(
   parameter int WINDOW     = 10,
   parameter int ANGLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_heading_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_mean_heading,
   output logic        rsp_no_direction
);
   import cmhf_pkg::*;

   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W = 17 + $clog2(WINDOW);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_LOAD  = 3'd2;
   localparam logic [2:0] S_ROT   = 3'd3;
   localparam logic [2:0] S_ACC   = 3'd4;
   localparam logic [2:0] S_VLOAD = 3'd5;
   localparam logic [2:0] S_VEC   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   localparam logic signed [CORDIC_W-1:0] CORDIC_START = CORDIC_W'(652032874);
   localparam logic signed [CORDIC_W-1:0] HALF_TURN    = CORDIC_W'(64'h8000_0000);
   localparam logic [31:0]                ROUND_HALF   = 32'd1 << (31 - ANGLE_BITS);
   localparam logic [ITER_W-1:0]          LAST_ITER    = ITER_W'(CORDIC_ITERS - 1);

   logic [2:0]              state_ff;
   logic [2:0]              state_in;
   logic [PTR_W-1:0]        idx_ff;
   logic [PTR_W-1:0]        idx_in;
   logic [ITER_W-1:0]       iter_ff;
   logic [ITER_W-1:0]       iter_in;
   logic [1:0]              quad_ff;
   logic [1:0]              quad_in;
   logic signed [SUM_W-1:0] sum_s_ff;
   logic signed [SUM_W-1:0] sum_s_in;
   logic signed [SUM_W-1:0] sum_c_ff;
   logic signed [SUM_W-1:0] sum_c_in;
   logic                    nodir_ff;
   logic                    nodir_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [15:0]             rsp_heading_ff;
   logic [15:0]             rsp_heading_in;
   logic                    rsp_nodir_ff;
   logic                    rsp_nodir_in;

   logic                       accept;
   logic [ANGLE_BITS+15:0]     sample_ext;
   logic [ANGLE_BITS-1:0]      ring_rd;
   logic [31:0]                angle32;
   cordic_ctrl_type            cordic_ctrl;
   logic signed [CORDIC_W-1:0] load_x;
   logic signed [CORDIC_W-1:0] load_y;
   logic signed [CORDIC_W-1:0] load_z;
   logic signed [CORDIC_W-1:0] cx;
   logic signed [CORDIC_W-1:0] cy;
   logic signed [CORDIC_W-1:0] cz;
   logic signed [CORDIC_W-1:0] cos_v;
   logic signed [CORDIC_W-1:0] sin_v;
   logic signed [15:0]         cos_q;
   logic signed [15:0]         sin_q;
   logic signed [CORDIC_W-1:0] vx;
   logic signed [CORDIC_W-1:0] vy;
   logic [31:0]                z_round;
   logic [ANGLE_BITS+15:0]     mean_ext;
   logic                       rsp_free;

   // Round a Q2.30 value to Q1.15 and saturate.
   function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] r;
      logic signed [15:0]         q;
      r = (v + CORDIC_W'(16384)) >>> 15;
      if (r > CORDIC_W'(32767)) begin
         q = 16'sh7FFF;
      end else if (r < -CORDIC_W'(32768)) begin
         q = 16'sh8000;
      end else begin
         q = r[15:0];
      end
      return q;
   endfunction

   assign accept     = req_valid && req_ready;
   assign sample_ext = {{ANGLE_BITS{1'b0}}, req_heading_sample};

   cmhf_ring #(
      .WINDOW     (WINDOW),
      .ANGLE_BITS (ANGLE_BITS),
      .PTR_W      (PTR_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_data (sample_ext[ANGLE_BITS-1:0]),
      .rd_addr (idx_ff),
      .rd_data (ring_rd)
   );

   cmhf_cordic u_cordic (
      .clock  (clock),
      .ctrl   (cordic_ctrl),
      .load_x (load_x),
      .load_y (load_y),
      .load_z (load_z),
      .x      (cx),
      .y      (cy),
      .z      (cz)
   );

   assign angle32 = {ring_rd, {(32 - ANGLE_BITS){1'b0}}};

   // Undo the quadrant fold with exact quarter-turn swaps.
   always_comb begin
      unique case (quad_ff)
         2'd1: begin
            cos_v = -cy;
            sin_v = cx;
         end
         2'd2: begin
            cos_v = -cx;
            sin_v = -cy;
         end
         2'd3: begin
            cos_v = cy;
            sin_v = -cx;
         end
         default: begin
            cos_v = cx;
            sin_v = cy;
         end
      endcase
      cos_q = to_q15(cos_v);
      sin_q = to_q15(sin_v);
   end

   assign vx = {{(CORDIC_W - SUM_W){sum_c_ff[SUM_W-1]}}, sum_c_ff} <<< 8;
   assign vy = {{(CORDIC_W - SUM_W){sum_s_ff[SUM_W-1]}}, sum_s_ff} <<< 8;

   assign z_round  = cz[31:0] + ROUND_HALF;
   assign mean_ext = {16'b0, z_round[31 -: ANGLE_BITS]};
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      iter_in        = iter_ff;
      quad_in        = quad_ff;
      sum_s_in       = sum_s_ff;
      sum_c_in       = sum_c_ff;
      nodir_in       = nodir_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_heading_in = rsp_heading_ff;
      rsp_nodir_in   = rsp_nodir_ff;
      cordic_ctrl    = '{load: 1'b0, step: 1'b0, vec_mode: 1'b0, iter: iter_ff};
      load_x         = CORDIC_START;
      load_y         = '0;
      load_z         = {{(CORDIC_W - 30){1'b0}}, angle32[29:0]};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               sum_s_in = '0;
               sum_c_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cordic_ctrl.load = 1'b1;
            quad_in          = angle32[31:30];
            iter_in          = '0;
            state_in         = S_ROT;
         end
         S_ROT: begin
            cordic_ctrl.step = 1'b1;
            iter_in          = iter_ff + ITER_W'(1);
            if (iter_ff == LAST_ITER) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            sum_s_in = sum_s_ff + {{(SUM_W - 16){sin_q[15]}}, sin_q};
            sum_c_in = sum_c_ff + {{(SUM_W - 16){cos_q[15]}}, cos_q};
            if (idx_ff == PTR_W'(WINDOW - 1)) begin
               state_in = S_VLOAD;
            end else begin
               idx_in   = idx_ff + PTR_W'(1);
               state_in = S_READ;
            end
         end
         S_VLOAD: begin
            nodir_in = (sum_s_ff == '0) && (sum_c_ff == '0);
            iter_in  = '0;
            if ((sum_s_ff == '0) && (sum_c_ff == '0)) begin
               state_in = S_DONE;
            end else begin
               // Fold a left-half vector into the right half, start at half a turn.
               cordic_ctrl.load = 1'b1;
               if (vx[CORDIC_W-1]) begin
                  load_x = -vx;
                  load_y = -vy;
                  load_z = HALF_TURN;
               end else begin
                  load_x = vx;
                  load_y = vy;
                  load_z = '0;
               end
               state_in = S_VEC;
            end
         end
         S_VEC: begin
            cordic_ctrl.step     = 1'b1;
            cordic_ctrl.vec_mode = 1'b1;
            iter_in              = iter_ff + ITER_W'(1);
            if (iter_ff == LAST_ITER) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Hold until the result register is free.
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_nodir_in   = nodir_ff;
               rsp_heading_in = nodir_ff ? 16'd0 : mean_ext[15:0];
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff        <= quad_in;
      sum_s_ff       <= sum_s_in;
      sum_c_ff       <= sum_c_in;
      nodir_ff       <= nodir_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_nodir_ff   <= rsp_nodir_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_heading = rsp_heading_ff;
   assign rsp_no_direction = rsp_nodir_ff;

   a_accept_starts_read : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_READ))
      else $error("accepted transaction did not start the ring sweep");

   a_rot_ends_in_acc : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROT) && (iter_ff == LAST_ITER) |=> (state_ff == S_ACC))
      else $error("rotation did not end after the last iteration");

   a_idx_in_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= PTR_W'(WINDOW - 1))
      else $error("ring index out of range");

   a_nodir_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_nodir_ff |-> (rsp_heading_ff == 16'd0))
      else $error("no-direction result carries a nonzero heading");

   a_pending_kept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && rsp_valid_ff && !rsp_ready |=> (state_ff == S_DONE))
      else $error("result left the sequencer while the output was stalled");

endmodule
